### rtl/core/ppt_pkg.sv
// Shared types and constants for the polygon pose transform block.
// No dependencies; every other file in rtl/core but ppt_fifo imports this package.
`timescale 1ns / 1ps

package ppt_pkg;

    // Coordinate width of world outputs and box fields.
    localparam int COORD_WIDTH = 32;

    // Width used while adding the position and saturating.
    localparam int SAT_W = (COORD_WIDTH > 37) ? COORD_WIDTH + 1 : 38;

    localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    // Register map, word index on paddr[4:2].
    typedef enum logic [2:0] {
        REG_QUAT_W      = 3'd0,
        REG_QUAT_X      = 3'd1,
        REG_QUAT_Y      = 3'd2,
        REG_QUAT_Z      = 3'd3,
        REG_POS_X       = 3'd4,
        REG_POS_Y       = 3'd5,
        REG_HALF_THICK  = 3'd6,
        REG_BOTTOM_MODE = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        ROT_IDLE,
        ROT_RUN,
        ROT_DRAIN,
        ROT_LOAD
    } t_rot_state;

    typedef struct packed {
        logic signed [31:0] body_x;
        logic signed [31:0] body_y;
        logic               last_vertex;
    } t_vertex;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] world_x;
        logic signed [COORD_WIDTH-1:0] world_y;
        logic signed [COORD_WIDTH-1:0] box_min_x;
        logic signed [COORD_WIDTH-1:0] box_max_x;
        logic signed [COORD_WIDTH-1:0] box_min_y;
        logic signed [COORD_WIDTH-1:0] box_max_y;
        logic                          box_done;
    } t_result;

    // Classified item waiting between front and back.
    typedef struct packed {
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic signed [31:0] zb;
        logic               last;
    } t_work;

    // Rows 0 and 1 of the rotation matrix, Q2.30.
    typedef struct packed {
        logic signed [31:0] r00;
        logic signed [31:0] r01;
        logic signed [31:0] r02;
        logic signed [31:0] r10;
        logic signed [31:0] r11;
        logic signed [31:0] r12;
    } t_rot_terms;

endpackage

### rtl/core/ppt_fifo.sv
// Small first-word-fall-through queue, register array storage.
// No dependencies.
`timescale 1ns / 1ps

module ppt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_wr,
    input  logic [WIDTH-1:0]               i_wdata,
    input  logic                           i_rd,
    output logic [WIDTH-1:0]               o_rdata,
    output logic                           o_empty,
    output logic                           o_full,
    output logic [$clog2(DEPTH+1)-1:0]     o_count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             wr_en;
    logic             rd_en;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_count = r_count;
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### rtl/core/ppt_rot.sv
// Rotation term derivation: nine quaternion products on one shared multiplier.
// Depends on ppt_pkg.
`timescale 1ns / 1ps

module ppt_rot (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [31:0]  i_qw,
    input  logic signed [31:0]  i_qx,
    input  logic signed [31:0]  i_qy,
    input  logic signed [31:0]  i_qz,
    output logic                o_busy,
    output ppt_pkg::t_rot_terms o_terms
);
    import ppt_pkg::*;

    localparam int NUM_PROD = 9;
    localparam logic [3:0] PR_XX = 4'd0;
    localparam logic [3:0] PR_YY = 4'd1;
    localparam logic [3:0] PR_ZZ = 4'd2;
    localparam logic [3:0] PR_XY = 4'd3;
    localparam logic [3:0] PR_XZ = 4'd4;
    localparam logic [3:0] PR_YZ = 4'd5;
    localparam logic [3:0] PR_WX = 4'd6;
    localparam logic [3:0] PR_WY = 4'd7;
    localparam logic [3:0] PR_WZ = 4'd8;

    localparam logic signed [63:0] RND_HALF = 64'sd536870912;
    localparam logic signed [37:0] TERM_ONE = 38'sd1073741824;
    localparam logic signed [37:0] SAT_HI   = 38'sd2147483647;
    localparam logic signed [37:0] SAT_LO   = -38'sd2147483648;

    t_rot_state         r_state, n_state;
    logic [3:0]         r_step;
    logic               issue;
    logic               load;
    logic signed [31:0] op_a, op_b;
    logic signed [63:0] r_prod;
    logic signed [63:0] prod_rnd;
    logic               r_pvld;
    logic [3:0]         r_pidx;
    logic signed [33:0] r_pr [NUM_PROD];
    t_rot_terms         r_terms;
    t_rot_terms         n_terms;

    function automatic logic signed [37:0] sx38(input logic signed [33:0] v);
        sx38 = {{4{v[33]}}, v};
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
        if (v > SAT_HI) begin
            sat32 = SAT_HI[31:0];
        end else if (v < SAT_LO) begin
            sat32 = SAT_LO[31:0];
        end else begin
            sat32 = v[31:0];
        end
    endfunction

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ROT_IDLE:  n_state = ROT_IDLE;
            ROT_RUN:   n_state = (r_step == PR_WZ) ? ROT_DRAIN : ROT_RUN;
            ROT_DRAIN: n_state = ROT_LOAD;
            ROT_LOAD:  n_state = ROT_IDLE;
            default:   n_state = ROT_IDLE;
        endcase
        if (i_start) begin
            n_state = ROT_RUN;
        end
    end

    // state outputs
    always_comb begin
        issue  = 1'b0;
        load   = 1'b0;
        o_busy = 1'b1;
        case (r_state)
            ROT_IDLE:  o_busy = 1'b0;
            ROT_RUN:   issue  = 1'b1;
            ROT_DRAIN: issue  = 1'b0;
            ROT_LOAD:  load   = 1'b1;
            default:   o_busy = 1'b0;
        endcase
    end

    always_comb begin
        case (r_step)
            PR_XX:   begin op_a = i_qx; op_b = i_qx; end
            PR_YY:   begin op_a = i_qy; op_b = i_qy; end
            PR_ZZ:   begin op_a = i_qz; op_b = i_qz; end
            PR_XY:   begin op_a = i_qx; op_b = i_qy; end
            PR_XZ:   begin op_a = i_qx; op_b = i_qz; end
            PR_YZ:   begin op_a = i_qy; op_b = i_qz; end
            PR_WX:   begin op_a = i_qw; op_b = i_qx; end
            PR_WY:   begin op_a = i_qw; op_b = i_qy; end
            default: begin op_a = i_qw; op_b = i_qz; end
        endcase
    end

    // round half up to Q2.30
    assign prod_rnd = r_prod + RND_HALF;

    always_comb begin
        n_terms.r00 = sat32(TERM_ONE - ((sx38(r_pr[PR_YY]) + sx38(r_pr[PR_ZZ])) <<< 1));
        n_terms.r01 = sat32((sx38(r_pr[PR_XY]) - sx38(r_pr[PR_WZ])) <<< 1);
        n_terms.r02 = sat32((sx38(r_pr[PR_XZ]) + sx38(r_pr[PR_WY])) <<< 1);
        n_terms.r10 = sat32((sx38(r_pr[PR_XY]) + sx38(r_pr[PR_WZ])) <<< 1);
        n_terms.r11 = sat32(TERM_ONE - ((sx38(r_pr[PR_XX]) + sx38(r_pr[PR_ZZ])) <<< 1));
        n_terms.r12 = sat32((sx38(r_pr[PR_YZ]) - sx38(r_pr[PR_WX])) <<< 1);
    end

    always_ff @(posedge i_clk) begin
        r_prod <= op_a * op_b;
        r_pidx <= r_step;
        if (r_pvld) begin
            r_pr[r_pidx] <= prod_rnd[63:30];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ROT_IDLE;
            r_step  <= '0;
            r_pvld  <= 1'b0;
            // identity for the reset quaternion (w = 1)
            r_terms <= '{r00: 32'sd1073741824, r01: '0, r02: '0,
                         r10: '0, r11: 32'sd1073741824, r12: '0};
        end else begin
            r_state <= n_state;
            r_pvld  <= issue;
            if (i_start || (r_state != ROT_RUN)) begin
                r_step <= '0;
            end else begin
                r_step <= r_step + 1'b1;
            end
            if (load) begin
                r_terms <= n_terms;
            end
        end
    end

    assign o_terms = r_terms;

    a_load_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ROT_LOAD && !i_start) |=> !o_busy)
        else $error("rotation unit still busy after loading terms");

endmodule

### rtl/core/ppt_front.sv
// Front end: accepts vertices, attaches the face depth and queues the work.
// Depends on ppt_pkg and ppt_fifo.
`timescale 1ns / 1ps

module ppt_front #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ppt_pkg::t_vertex i_vertex,
    output logic             o_full,
    input  logic             i_rot_busy,
    input  logic [30:0]      i_half_thick,
    input  logic             i_bottom_mode,
    input  logic             i_pop,
    output logic             o_empty,
    output ppt_pkg::t_work   o_work
);
    import ppt_pkg::*;

    t_work                          work_in;
    logic [$bits(t_work)-1:0]       work_out;
    logic                           q_full;
    logic                           accept;
    logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;

    // stall intake while the rotation terms are being rebuilt
    assign o_full = q_full || i_rot_busy;
    assign accept = i_push && !o_full;

    always_comb begin
        work_in.bx   = i_vertex.body_x;
        work_in.by   = i_vertex.body_y;
        work_in.last = i_vertex.last_vertex;
        work_in.zb   = i_bottom_mode ? -$signed({1'b0, i_half_thick}) : 32'sd0;
    end

    ppt_fifo #(
        .WIDTH ($bits(t_work)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (accept),
        .i_wdata (work_in),
        .i_rd    (i_pop),
        .o_rdata (work_out),
        .o_empty (o_empty),
        .o_full  (q_full),
        .o_count (q_count)
    );

    assign o_work = t_work'(work_out);

    a_no_push_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rot_busy && i_push) |=> (q_count == $past(q_count) - (($past(i_pop) &&
            $past(q_count) != '0) ? 1'b1 : 1'b0)))
        else $error("vertex queued while rotation terms were being rebuilt");

endmodule

### rtl/core/ppt_back.sv
// Back end: multiply-add pipeline, rounding, saturation, running box and result queue.
// Depends on ppt_pkg and ppt_fifo.
`timescale 1ns / 1ps

module ppt_back #(
    parameter int RESULT_DEPTH = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_work_empty,
    input  ppt_pkg::t_work      i_work,
    output logic                o_work_pop,
    input  ppt_pkg::t_rot_terms i_terms,
    input  logic signed [31:0]  i_pos_x,
    input  logic signed [31:0]  i_pos_y,
    input  logic                i_pop,
    output logic                o_empty,
    output ppt_pkg::t_result    o_result
);
    import ppt_pkg::*;

    localparam int NSTG  = 4;
    localparam int CNT_W = $clog2(RESULT_DEPTH + 1);
    localparam int RSV_W = $clog2(RESULT_DEPTH + NSTG + 1) + 1;
    localparam logic signed [65:0] RND_HALF = 66'sd536870912;

    logic [NSTG-1:0]              r_vld;
    logic [NSTG-1:0]              r_last;
    logic signed [63:0]           r1_px [3];
    logic signed [63:0]           r1_py [3];
    logic signed [64:0]           r2_sx, r2_sy;
    logic signed [63:0]           r2_px, r2_py;
    logic signed [65:0]           sum_x, sum_y;
    logic signed [35:0]           r3_rx, r3_ry;
    logic signed [SAT_W-1:0]      off_x, off_y;
    logic signed [COORD_WIDTH-1:0] r4_wx, r4_wy;
    logic signed [COORD_WIDTH-1:0] r_min_x, r_max_x, r_min_y, r_max_y;
    logic signed [COORD_WIDTH-1:0] n_min_x, n_max_x, n_min_y, n_max_y;
    t_result                      res;
    logic [$bits(t_result)-1:0]   res_out;
    logic                         q_full;
    logic [CNT_W-1:0]             q_count;
    logic [RSV_W-1:0]             reserved;

    function automatic logic signed [COORD_WIDTH-1:0] sat_coord(
        input logic signed [SAT_W-1:0] v
    );
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        hi = {{(SAT_W-COORD_WIDTH){1'b0}}, COORD_MAX};
        lo = {{(SAT_W-COORD_WIDTH){1'b1}}, COORD_MIN};
        if (v > hi) begin
            sat_coord = COORD_MAX;
        end else if (v < lo) begin
            sat_coord = COORD_MIN;
        end else begin
            sat_coord = v[COORD_WIDTH-1:0];
        end
    endfunction

    // an item only enters when the result queue has a slot for it
    assign reserved   = RSV_W'(q_count) + RSV_W'($countones(r_vld));
    assign o_work_pop = !i_work_empty && (reserved < RSV_W'(RESULT_DEPTH));

    // single rounding of the exact three-product sum
    assign sum_x = {r2_sx[64], r2_sx} + {{2{r2_px[63]}}, r2_px} + RND_HALF;
    assign sum_y = {r2_sy[64], r2_sy} + {{2{r2_py[63]}}, r2_py} + RND_HALF;
    assign off_x = SAT_W'(r3_rx) + SAT_W'(i_pos_x);
    assign off_y = SAT_W'(r3_ry) + SAT_W'(i_pos_y);

    always_ff @(posedge i_clk) begin
        r1_px[0] <= i_terms.r00 * i_work.bx;
        r1_px[1] <= i_terms.r01 * i_work.by;
        r1_px[2] <= i_terms.r02 * i_work.zb;
        r1_py[0] <= i_terms.r10 * i_work.bx;
        r1_py[1] <= i_terms.r11 * i_work.by;
        r1_py[2] <= i_terms.r12 * i_work.zb;
        r2_sx    <= {r1_px[0][63], r1_px[0]} + {r1_px[1][63], r1_px[1]};
        r2_sy    <= {r1_py[0][63], r1_py[0]} + {r1_py[1][63], r1_py[1]};
        r2_px    <= r1_px[2];
        r2_py    <= r1_py[2];
        r3_rx    <= sum_x[65:30];
        r3_ry    <= sum_y[65:30];
        r4_wx    <= sat_coord(off_x);
        r4_wy    <= sat_coord(off_y);
        r_last   <= {r_last[NSTG-2:0], i_work.last};
    end

    always_comb begin
        n_min_x = (r4_wx < r_min_x) ? r4_wx : r_min_x;
        n_max_x = (r4_wx > r_max_x) ? r4_wx : r_max_x;
        n_min_y = (r4_wy < r_min_y) ? r4_wy : r_min_y;
        n_max_y = (r4_wy > r_max_y) ? r4_wy : r_max_y;
        res.world_x   = r4_wx;
        res.world_y   = r4_wy;
        res.box_min_x = n_min_x;
        res.box_max_x = n_max_x;
        res.box_min_y = n_min_y;
        res.box_max_y = n_max_y;
        res.box_done  = r_last[NSTG-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_min_x <= COORD_MAX;
            r_min_y <= COORD_MAX;
            r_max_x <= COORD_MIN;
            r_max_y <= COORD_MIN;
        end else begin
            r_vld <= {r_vld[NSTG-2:0], o_work_pop};
            if (r_vld[NSTG-1]) begin
                if (r_last[NSTG-1]) begin
                    r_min_x <= COORD_MAX;
                    r_min_y <= COORD_MAX;
                    r_max_x <= COORD_MIN;
                    r_max_y <= COORD_MIN;
                end else begin
                    r_min_x <= n_min_x;
                    r_min_y <= n_min_y;
                    r_max_x <= n_max_x;
                    r_max_y <= n_max_y;
                end
            end
        end
    end

    ppt_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (RESULT_DEPTH)
    ) u_results (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (r_vld[NSTG-1]),
        .i_wdata (res),
        .i_rd    (i_pop),
        .o_rdata (res_out),
        .o_empty (o_empty),
        .o_full  (q_full),
        .o_count (q_count)
    );

    assign o_result = t_result'(res_out);

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NSTG-1] |-> !q_full)
        else $error("result written into a full result queue");

    a_reserve_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        reserved <= RSV_W'(RESULT_DEPTH))
        else $error("items in flight exceed result queue space");

    a_box_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NSTG-1] && r_last[NSTG-1]) |=>
            (r_min_x == COORD_MAX && r_max_y == COORD_MIN))
        else $error("bounding box not restarted after last vertex");

endmodule

### rtl/core/polygon_pose_transform_bbox_top.sv
// Top level of the polygon pose transform with running bounding box.
// Depends on ppt_pkg, ppt_rot, ppt_front, ppt_back (and ppt_fifo below them).
`timescale 1ns / 1ps

// Channel     Direction  Handshake                        Payload
// vertex      in         push / full                      i_vertex (t_vertex)
// result      out        pop / empty                      o_result (t_result)
// config      in/out     psel penable pwrite pready       paddr, pwdata, prdata
//
// Cycles: one vertex per cycle sustained while results are taken and no rotation
//   rebuild runs. A taken vertex passes the work queue, then one register stage
//   each for the six products, the partial sum, the rounding, the saturation and
//   the box update into the result queue on its way to the result port.
// A write to any quaternion register rebuilds the rotation terms on one shared
//   multiplier: full is high while the rebuild runs.
// Reset: synchronous, active low. Registers return to w = 1, box accumulators
//   to empty, and the rotation terms to identity at once; no clearing pass.
// Stalls: the result queue absorbs a stalled consumer; once it and the work
//   queue fill, full rises. Each side stalls without stopping the other until the queues fill.

module polygon_pose_transform_bbox_top #(
    parameter int QUEUE_DEPTH  = 4,
    parameter int RESULT_DEPTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // vertex items in
    input  logic             push,
    output logic             full,
    input  ppt_pkg::t_vertex i_vertex,
    // result items out
    output logic             empty,
    input  logic             pop,
    output ppt_pkg::t_result o_result,
    // configuration
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [4:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import ppt_pkg::*;

    logic signed [31:0] r_quat_w, r_quat_x, r_quat_y, r_quat_z;
    logic signed [31:0] r_pos_x, r_pos_y;
    logic [30:0]        r_half_thick;
    logic               r_bottom_mode;

    t_reg_idx   reg_idx;
    logic       cfg_wr;
    logic       rot_start;
    logic       rot_busy;
    t_rot_terms terms;
    t_work      work;
    logic       work_empty;
    logic       work_pop;

    assign pready    = 1'b1;
    assign reg_idx   = t_reg_idx'(paddr[4:2]);
    assign cfg_wr    = psel && penable && pwrite && pready;
    // any quaternion write restarts the rotation rebuild
    assign rot_start = cfg_wr &&
                       (reg_idx inside {REG_QUAT_W, REG_QUAT_X, REG_QUAT_Y, REG_QUAT_Z});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quat_w      <= 32'sd1073741824;
            r_quat_x      <= '0;
            r_quat_y      <= '0;
            r_quat_z      <= '0;
            r_pos_x       <= '0;
            r_pos_y       <= '0;
            r_half_thick  <= '0;
            r_bottom_mode <= 1'b1;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_QUAT_W:      r_quat_w      <= pwdata;
                REG_QUAT_X:      r_quat_x      <= pwdata;
                REG_QUAT_Y:      r_quat_y      <= pwdata;
                REG_QUAT_Z:      r_quat_z      <= pwdata;
                REG_POS_X:       r_pos_x       <= pwdata;
                REG_POS_Y:       r_pos_y       <= pwdata;
                REG_HALF_THICK:  r_half_thick  <= pwdata[30:0];
                REG_BOTTOM_MODE: r_bottom_mode <= pwdata[0];
                default:         r_bottom_mode <= r_bottom_mode;
            endcase
        end
    end

    // register readback, narrow fields zero extended
    always_comb begin
        case (reg_idx)
            REG_QUAT_W:      prdata = r_quat_w;
            REG_QUAT_X:      prdata = r_quat_x;
            REG_QUAT_Y:      prdata = r_quat_y;
            REG_QUAT_Z:      prdata = r_quat_z;
            REG_POS_X:       prdata = r_pos_x;
            REG_POS_Y:       prdata = r_pos_y;
            REG_HALF_THICK:  prdata = {1'b0, r_half_thick};
            REG_BOTTOM_MODE: prdata = {31'd0, r_bottom_mode};
            default:         prdata = '0;
        endcase
    end

    ppt_rot u_rot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (rot_start),
        .i_qw    (r_quat_w),
        .i_qx    (r_quat_x),
        .i_qy    (r_quat_y),
        .i_qz    (r_quat_z),
        .o_busy  (rot_busy),
        .o_terms (terms)
    );

    ppt_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_vertex      (i_vertex),
        .o_full        (full),
        .i_rot_busy    (rot_busy),
        .i_half_thick  (r_half_thick),
        .i_bottom_mode (r_bottom_mode),
        .i_pop         (work_pop),
        .o_empty       (work_empty),
        .o_work        (work)
    );

    ppt_back #(
        .RESULT_DEPTH (RESULT_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_work_empty (work_empty),
        .i_work       (work),
        .o_work_pop   (work_pop),
        .i_terms      (terms),
        .i_pos_x      (r_pos_x),
        .i_pos_y      (r_pos_y),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_result     (o_result)
    );

endmodule

### test/ppt_checker.sv
// Scoreboard for the polygon pose transform: predicts world vertices and boxes.
// Depends on ppt_pkg; watches the vertex, result and configuration channels.
`timescale 1ns / 1ps

module ppt_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic             i_full,
    input  ppt_pkg::t_vertex i_vertex,
    input  logic             i_empty,
    input  logic             i_pop,
    input  ppt_pkg::t_result i_result,
    input  logic             i_psel,
    input  logic             i_penable,
    input  logic             i_pwrite,
    input  logic [4:0]       i_paddr,
    input  logic [31:0]      i_pwdata,
    input  logic             i_pready,
    output int               o_errors,
    output int               o_outstanding
);
    import ppt_pkg::*;

    localparam longint Q30_ONE  = 64'sd1073741824;
    localparam longint Q30_HALF = 64'sd536870912;
    localparam logic signed [95:0] HALF_WIDE = 96'sd536870912;

    // Shadow copy of the pose registers and derived rotation rows.
    logic signed [31:0] quat [4];
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [30:0]        half_thick;
    logic               bottom_mode;
    logic signed [31:0] rot [6];

    logic signed [COORD_WIDTH-1:0] min_x, max_x, min_y, max_y;

    t_result due_results[$];
    int      errors = 0;

    assign o_errors = errors;

    function automatic longint q30_mul(input longint a, input longint b);
        return (a * b + Q30_HALF) >>> 30;
    endfunction

    function automatic logic signed [31:0] sat32(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fff_ffff;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic void rebuild_rotation();
        longint w, x, y, z, xx, yy, zz, xy, xz, yz, wx, wy, wz;
        w  = quat[0];
        x  = quat[1];
        y  = quat[2];
        z  = quat[3];
        xx = q30_mul(x, x);
        yy = q30_mul(y, y);
        zz = q30_mul(z, z);
        xy = q30_mul(x, y);
        xz = q30_mul(x, z);
        yz = q30_mul(y, z);
        wx = q30_mul(w, x);
        wy = q30_mul(w, y);
        wz = q30_mul(w, z);
        rot[0] = sat32(Q30_ONE - 2 * (yy + zz));
        rot[1] = sat32(2 * (xy - wz));
        rot[2] = sat32(2 * (xz + wy));
        rot[3] = sat32(2 * (xy + wz));
        rot[4] = sat32(Q30_ONE - 2 * (xx + zz));
        rot[5] = sat32(2 * (yz - wx));
    endfunction

    function automatic void clear_box();
        min_x = COORD_MAX;
        min_y = COORD_MAX;
        max_x = COORD_MIN;
        max_y = COORD_MIN;
    endfunction

    // pos + r0*bx + r1*by + r2*zb, exact sum, one round half up, saturate
    function automatic logic signed [COORD_WIDTH-1:0] place_axis(
        input logic signed [31:0] pos, r0, r1, r2, bx, by, zb);
        logic signed [95:0] a0, a1, a2, b0, b1, b2, sum;
        a0  = r0;
        a1  = r1;
        a2  = r2;
        b0  = bx;
        b1  = by;
        b2  = zb;
        sum = a0 * b0 + a1 * b1 + a2 * b2;
        sum = (sum + HALF_WIDE) >>> 30;
        sum = sum + pos;
        if (sum > COORD_MAX)
            return COORD_MAX;
        if (sum < COORD_MIN)
            return COORD_MIN;
        return sum[COORD_WIDTH-1:0];
    endfunction

    function automatic t_result transform_vertex(input t_vertex v);
        t_result            r;
        logic signed [31:0] zb;
        zb = bottom_mode ? -$signed({1'b0, half_thick}) : 32'sd0;
        r.world_x = place_axis(pos_x, rot[0], rot[1], rot[2], v.body_x, v.body_y, zb);
        r.world_y = place_axis(pos_y, rot[3], rot[4], rot[5], v.body_x, v.body_y, zb);
        if (r.world_x < min_x) min_x = r.world_x;
        if (r.world_x > max_x) max_x = r.world_x;
        if (r.world_y < min_y) min_y = r.world_y;
        if (r.world_y > max_y) max_y = r.world_y;
        r.box_min_x = min_x;
        r.box_max_x = max_x;
        r.box_min_y = min_y;
        r.box_max_y = max_y;
        r.box_done  = v.last_vertex;
        if (v.last_vertex)
            clear_box();
        return r;
    endfunction

    function automatic void apply_write(input t_reg_idx idx, input logic [31:0] data);
        case (idx)
            REG_QUAT_W, REG_QUAT_X, REG_QUAT_Y, REG_QUAT_Z: begin
                quat[idx] = data;
                rebuild_rotation();
            end
            REG_POS_X:       pos_x = data;
            REG_POS_Y:       pos_y = data;
            REG_HALF_THICK:  half_thick = data[30:0];
            REG_BOTTOM_MODE: bottom_mode = data[0];
            default: ;
        endcase
    endfunction

    task automatic check_field(input string name,
                               input logic signed [COORD_WIDTH-1:0] want,
                               input logic signed [COORD_WIDTH-1:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            quat        = '{32'sh4000_0000, 32'sd0, 32'sd0, 32'sd0};
            pos_x       = '0;
            pos_y       = '0;
            half_thick  = '0;
            bottom_mode = 1'b1;
            rebuild_rotation();
            clear_box();
            due_results.delete();
            o_outstanding <= 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready)
                apply_write(t_reg_idx'(i_paddr[4:2]), i_pwdata);

            if (i_pop && !i_empty) begin
                got = i_result;
                if (due_results.size() == 0) begin
                    errors++;
                    $display("%0t: result with no vertex outstanding, world_x %0d world_y %0d",
                             $time, got.world_x, got.world_y);
                end else begin
                    want = due_results.pop_front();
                    check_field("world_x", want.world_x, got.world_x);
                    check_field("world_y", want.world_y, got.world_y);
                    check_field("box_min_x", want.box_min_x, got.box_min_x);
                    check_field("box_max_x", want.box_max_x, got.box_max_x);
                    check_field("box_min_y", want.box_min_y, got.box_min_y);
                    check_field("box_max_y", want.box_max_y, got.box_max_y);
                    check_field("box_done", want.box_done, got.box_done);
                end
            end

            if (i_push && !i_full)
                due_results.insert(due_results.size(), transform_vertex(i_vertex));

            o_outstanding <= due_results.size();
        end
    end

endmodule

### test/tb.sv
// Testbench top for polygon_pose_transform_bbox_top: clock, reset, stimulus, verdict.
// Depends on ppt_pkg, the block's RTL and ppt_checker, which checks every result.
`timescale 1ns / 1ps

module tb;
    import ppt_pkg::*;

    // Cycles with neither a vertex nor a result accepted before giving up.
    localparam int STALL_LIMIT = 5000;
    localparam int RAND_PHASES = 9;
    localparam int PHASE_ITEMS = 84;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push    = 1'b0;
    logic        full;
    t_vertex     i_vertex = '0;
    logic        empty;
    logic        pop     = 1'b0;
    t_result     o_result;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [4:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    // calm: no idling on either side, set for one whole random phase
    logic calm = 1'b0;

    int errors;
    int outstanding;
    int vertices_sent = 0;
    int polygons_sent = 0;
    int poses_used    = 1;
    int results_seen  = 0;
    int quiet_cycles  = 0;

    always #4 i_clk = ~i_clk;

    polygon_pose_transform_bbox_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_vertex (i_vertex),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    ppt_checker chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_full        (full),
        .i_vertex      (i_vertex),
        .i_empty       (empty),
        .i_pop         (pop),
        .i_result      (o_result),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_pready      (pready),
        .o_errors      (errors),
        .o_outstanding (outstanding)
    );

    // Result side: take results about 64% of cycles, always while calm.
    always @(posedge i_clk) begin
        pop <= i_rst_n && (calm || $urandom_range(99) >= 36);
    end

    // Watchdog and result count; any accepted item on either side resets the count.
    always @(posedge i_clk) begin
        if (pop && !empty)
            results_seen <= results_seen + 1;
        if ((push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
            $display("** polygon_pose_transform_bbox_top: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_vertex vtx(input logic [31:0] x, input logic [31:0] y,
                                    input logic last);
        t_vertex v;
        v.body_x      = x;
        v.body_y      = y;
        v.last_vertex = last;
        return v;
    endfunction

    // Mostly within +/-256.0 so the box stays meaningful; some full range.
    function automatic logic [31:0] body_coord();
        if ($urandom_range(7) == 0)
            return $urandom();
        return $urandom_range(32'h0200_0000) - 32'h0100_0000;
    endfunction

    // Offers one item, with random idle cycles ahead of it, and returns at the
    // edge where the block takes it.
    task automatic send_vertex(input t_vertex v);
        while (!calm && $urandom_range(99) < 36) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push     <= 1'b1;
        i_vertex <= v;
        do @(posedge i_clk); while (full);
        vertices_sent++;
        if (v.last_vertex)
            polygons_sent++;
    endtask

    // close = 0 leaves the polygon open, so its box runs on past the next writes.
    task automatic send_polygon(input int len, input bit close);
        for (int i = 0; i < len; i++)
            send_vertex(vtx(body_coord(), body_coord(), close && i == len - 1));
    endtask

    // Stop offering items and wait until every expected result has come back.
    task automatic drain();
        push <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    // Setup cycle, access cycle, then idle so writes never overlap.
    task automatic write_reg(input t_reg_idx idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // kind 0: unit quaternion, moderate position
    // kind 1: raw quaternion, each component from -1.0 to 1.0, any position
    // kind 2: quaternion components of -1, 0 or 1; position and thickness at extremes or zero
    task automatic program_pose(input int kind);
        real    c [4];
        real    nrm;
        longint q;
        nrm = 0.0;
        for (int k = 0; k < 4; k++) begin
            c[k] = $urandom_range(2000000) / 1.0e6 - 1.0;
            nrm  = nrm + c[k] * c[k];
        end
        nrm = $sqrt(nrm);
        if (nrm < 0.01) begin
            c   = '{1.0, 0.0, 0.0, 0.0};
            nrm = 1.0;
        end
        for (int k = 0; k < 4; k++) begin
            case (kind)
                0:       q = $rtoi(c[k] / nrm * 1073741824.0);
                1:       q = longint'($urandom_range(32'h8000_0000)) - 64'sd1073741824;
                default: q = (longint'($urandom_range(2)) - 1) * 64'sd1073741824;
            endcase
            write_reg(t_reg_idx'(k), q[31:0]);
        end
        case (kind)
            0: begin
                write_reg(REG_POS_X, $urandom_range(32'h0200_0000) - 32'h0100_0000);
                write_reg(REG_POS_Y, $urandom_range(32'h0200_0000) - 32'h0100_0000);
                write_reg(REG_HALF_THICK, $urandom_range(32'h0100_0000));
            end
            1: begin
                write_reg(REG_POS_X, $urandom());
                write_reg(REG_POS_Y, $urandom());
                write_reg(REG_HALF_THICK, $urandom() & 32'h7fff_ffff);
            end
            default: begin
                write_reg(REG_POS_X, $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000);
                write_reg(REG_POS_Y, $urandom_range(1) ? 32'h7fff_ffff : 32'h0000_0000);
                write_reg(REG_HALF_THICK, $urandom_range(1) ? 32'h7fff_ffff : 32'h0);
            end
        endcase
        write_reg(REG_BOTTOM_MODE, $urandom_range(1));
        poses_used++;
    endtask

    initial begin
        int sent;
        int len;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed: reset pose is identity, so world equals body ----
        send_vertex(vtx(32'h0000_0000, 32'h0000_0000, 1'b0));
        send_vertex(vtx(32'h7fff_ffff, 32'h7fff_ffff, 1'b0));
        send_vertex(vtx(32'h8000_0000, 32'h8000_0000, 1'b0));
        send_vertex(vtx(32'h0000_0001, 32'hffff_ffff, 1'b0));
        send_vertex(vtx(32'hffff_ffff, 32'h0000_0001, 1'b1));
        // single vertex polygon: box collapses to the point
        send_vertex(vtx(32'h1234_5678, 32'hedcb_a987, 1'b1));

        // Position at the extremes, so world coordinates saturate both ways.
        // Bit 31 of the thickness write must be dropped.
        drain();
        write_reg(REG_POS_X, 32'h7fff_ffff);
        write_reg(REG_POS_Y, 32'h8000_0000);
        write_reg(REG_HALF_THICK, 32'hffff_ffff);
        write_reg(REG_BOTTOM_MODE, 32'h1);
        poses_used++;
        send_vertex(vtx(32'h7fff_ffff, 32'h8000_0000, 1'b0));
        send_vertex(vtx(32'h8000_0000, 32'h7fff_ffff, 1'b1));

        // Non unit quaternion: rotation terms overflow and saturate.
        drain();
        for (int k = 0; k < 4; k++)
            write_reg(t_reg_idx'(k), 32'h4000_0000);
        poses_used++;
        send_vertex(vtx(32'h7fff_ffff, 32'h7fff_ffff, 1'b0));
        send_vertex(vtx(32'h8000_0000, 32'h8000_0000, 1'b0));
        // a write in mid polygon leaves the running box alone
        drain();
        write_reg(REG_BOTTOM_MODE, 32'h0);
        send_vertex(vtx(32'h0001_0000, 32'h0000_8000, 1'b1));

        // R00 = 0.5 exactly: odd coordinates land on half steps, which round up.
        drain();
        write_reg(REG_QUAT_W, 32'h0);
        write_reg(REG_QUAT_X, 32'h0);
        write_reg(REG_QUAT_Y, 32'h2000_0000);
        write_reg(REG_QUAT_Z, 32'h0);
        write_reg(REG_POS_X, 32'h0);
        write_reg(REG_POS_Y, 32'h0);
        poses_used++;
        send_vertex(vtx(32'h0000_0001, 32'h0000_0001, 1'b0));
        send_vertex(vtx(32'hffff_ffff, 32'hffff_ffff, 1'b0));
        send_vertex(vtx(32'h0000_0003, 32'h0000_0003, 1'b1));

        // Quaternion component at -1.0.
        drain();
        write_reg(REG_QUAT_X, 32'hc000_0000);
        poses_used++;
        send_vertex(vtx(32'haaaa_aaaa, 32'h5555_5555, 1'b1));

        // ---- random: one pose per phase, polygons of 1 to 8 vertices ----
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            drain();
            calm <= (ph == 4);
            program_pose(ph % 3);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                len = $urandom_range(1, 8);
                send_polygon(len, 1'b1);
                sent += len;
            end
            // half the phases leave a polygon open across the next pose change
            if ($urandom_range(1))
                send_polygon($urandom_range(1, 3), 1'b0);
        end
        // close whatever is still open
        send_polygon(2, 1'b1);

        drain();
        repeat (12) @(posedge i_clk);

        $display("Run covered %0d vertices in %0d polygons over %0d poses, %0d results checked.",
                 vertices_sent, polygons_sent, poses_used, results_seen);
        if (errors == 0 && outstanding == 0)
            $display("** polygon_pose_transform_bbox_top: PASSED **");
        else
            $display("** polygon_pose_transform_bbox_top: FAILED **");
        $finish;
    end

endmodule

### sim.f
rtl/core/ppt_pkg.sv
rtl/core/ppt_fifo.sv
rtl/core/ppt_rot.sv
rtl/core/ppt_front.sv
rtl/core/ppt_back.sv
rtl/core/polygon_pose_transform_bbox_top.sv
test/ppt_checker.sv
test/tb.sv
